FILE: hw/rtl/sdft_pkg.sv
// ----------------------------------------------------------------------------
// sdft_pkg : shared types, constants and arithmetic helpers
// fixed-point helpers for the sun direction pipeline: q30 products, cordic
// rotation steps, square-root and division steps, output rounding
// ----------------------------------------------------------------------------
package sdft_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int OUT_FRAC_BITS_DEF = 15;
    localparam int SQRT_STEPS        = 31;
    localparam int DIV_STEPS         = 30;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [35:0] ang_t;
    typedef logic signed [33:0] crd_t;

    typedef struct packed {
        crd_t x;
        crd_t y;
        crd_t z;
        logic flip;
    } rot_t;

    typedef struct packed {
        logic [61:0] rem;
        logic [61:0] root;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [29:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [14:0] lat;
        logic [8:0]         day;
        logic [10:0]        mins;
        ang_t               ang_l;
        ang_t               ang_d;
        ang_t               ang_h;
        rot_t               rot_l;
        rot_t               rot_d;
        rot_t               rot_h;
        q30_t               sl;
        q30_t               cl;
        q30_t               ch;
        logic               sh_pos;
        q30_t               sd;
        q30_t               sd_sl;
        q30_t               sd_cl;
        sq_t                sq;
        q30_t               t1;
        q30_t               t2;
        q30_t               u1;
        q30_t               u2;
        q30_t               sel;
        logic signed [32:0] num;
        q30_t               cel;
        logic               neg;
        logic               sat;
        div_t               dv;
        q30_t               ratio;
        q30_t               zprod;
        q30_t               xprod;
        logic signed [15:0] sun_x;
        logic signed [15:0] sun_y;
        logic signed [15:0] sun_z;
    } item_t;

    localparam q30_t ONE_Q30      = 32'sd1073741824;
    localparam q30_t TILT_Q30     = 32'sd427295559;
    localparam crd_t INV_GAIN_Q30 = 34'sd652032874;
    localparam ang_t PI_Q30       = 36'sd3373259426;
    localparam ang_t HALF_PI_Q30  = 36'sd1686629713;
    localparam ang_t TWO_PI_Q30   = 36'sd6746518852;
    localparam ang_t LAT_RAD_Q40  = 36'sd191900981;
    localparam ang_t DAY_RAD_Q40  = 36'sd18914336361;
    localparam ang_t MIN_RAD_Q40  = 36'sd4797524517;
    localparam logic signed [15:0] DAY_ZERO = 16'sd173;
    localparam logic signed [15:0] MIN_NOON = 16'sd720;

    localparam longint ATAN_Q30 [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    function automatic q30_t clamp_unit(input logic signed [33:0] v);
        q30_t r;
        if (v > 34'sd1073741824)
            r = ONE_Q30;
        else if (v < -34'sd1073741824)
            r = -ONE_Q30;
        else
            r = 32'(v);
        return r;
    endfunction

    // q30 product, rounded half up
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        p = p >>> 30;
        return 32'(p);
    endfunction

    // radicand of the co-function: 2^60 - s^2
    function automatic logic [61:0] co_arg(input q30_t s);
        logic signed [63:0] p;
        q30_t c;
        c = clamp_unit(34'(s));
        p = c * c;
        return 62'(64'sd1152921504606846976 - p);
    endfunction

    // n * k in q40, rounded half up to q30
    function automatic ang_t ang_scale(input logic signed [15:0] n, input ang_t k);
        logic signed [51:0] p;
        p = n * k;
        p = p + 52'sd512;
        return p[45:10];
    endfunction

    // wrap onto (-pi, pi], fold into [-pi/2, pi/2], load the start vector
    function automatic rot_t rot_start(input ang_t a);
        ang_t z;
        rot_t r;
        z = a;
        r.flip = 1'b0;
        if (z > PI_Q30)
            z = z - TWO_PI_Q30;
        else if (z <= -PI_Q30)
            z = z + TWO_PI_Q30;
        if (z > HALF_PI_Q30)
        begin
            z = PI_Q30 - z;
            r.flip = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z = -PI_Q30 - z;
            r.flip = 1'b1;
        end
        r.x = INV_GAIN_Q30;
        r.y = '0;
        r.z = 34'(z);
        return r;
    endfunction

    function automatic rot_t rot_step(input rot_t r, input int unsigned i);
        crd_t dx;
        crd_t dy;
        crd_t at;
        rot_t o;
        dx = r.y >>> i;
        dy = r.x >>> i;
        at = 34'(ATAN_Q30[i[4:0]]);
        o  = r;
        if (!r.z[33])
        begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - at;
        end
        else
        begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + at;
        end
        return o;
    endfunction

    function automatic q30_t rot_sin(input rot_t r);
        return clamp_unit(r.y);
    endfunction

    function automatic q30_t rot_cos(input rot_t r);
        return clamp_unit(r.flip ? -r.x : r.x);
    endfunction

    // one digit of the floor square root
    function automatic sq_t sq_step(input sq_t s, input int unsigned j);
        logic [61:0] bitv;
        logic [61:0] trial;
        sq_t o;
        bitv  = 62'd1 << (60 - 2 * j);
        trial = s.root + bitv;
        o     = s;
        if (s.rem >= trial)
        begin
            o.rem  = s.rem - trial;
            o.root = (s.root >> 1) + bitv;
        end
        else
        begin
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // one restoring division step, divisor non-negative
    function automatic div_t div_step(input div_t d, input q30_t den);
        logic [32:0] r2;
        logic [32:0] dn;
        div_t o;
        r2 = {d.rem, 1'b0};
        dn = {1'b0, $unsigned(den)};
        if (r2 >= dn)
        begin
            o.rem = 32'(r2 - dn);
            o.quo = {d.quo[28:0], 1'b1};
        end
        else
        begin
            o.rem = r2[31:0];
            o.quo = {d.quo[28:0], 1'b0};
        end
        return o;
    endfunction

    // q30 to the output format, rounded half up, saturated
    function automatic logic signed [15:0] to_out(input logic signed [33:0] v,
                                                  input int unsigned sh);
        logic signed [34:0] q;
        logic signed [15:0] r;
        q = 35'(v);
        if (sh != 0)
            q = (q + (35'sd1 <<< (sh - 1))) >>> sh;
        if (q > 35'sd32767)
            r = 16'sh7fff;
        else if (q < -35'sd32768)
            r = 16'sh8000;
        else
            r = q[15:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/solar_direction_from_time_unit.sv
// ----------------------------------------------------------------------------
// solar_direction_from_time_unit : sun direction vector from latitude and time
// fully pipelined declination / hour-angle solar position; unless the output is held, one request a cycle
// ----------------------------------------------------------------------------
// Each request (latitude in hundredths of a degree, day of year, minute of
// day) gives one unit vector pointing at the sun, x/y/z in signed fixed point
// with OUT_FRAC_BITS fraction bits. A request can be taken on every clock
// that the pipeline is not held, and there are 137 + CORDIC_STEPS register
// stages in the chain. The stage count is set by the chain of units: three
// parallel cordic rotators of one step per stage, three one-digit-per-stage
// square roots (cos of declination, cos of elevation, sin of azimuth) and a
// one-bit-per-stage divider for the azimuth cosine. Valid bits run alongside
// the data. A stalled result holds the whole pipeline, so item_stall follows
// sun_stall only while a result is waiting at the output.
// ----------------------------------------------------------------------------
module solar_direction_from_time_unit
    import sdft_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [14:0] latitude,
    input  logic [8:0]         day_of_year,
    input  logic [10:0]        minute_of_day,
    output logic               sun_valid,
    input  logic               sun_stall,
    output logic signed [15:0] sun_x,
    output logic signed [15:0] sun_y,
    output logic signed [15:0] sun_z
);

    // stage map
    localparam int S_ANG   = 1;
    localparam int S_RED   = 2;
    localparam int S_CRD   = 3;
    localparam int S_P1    = S_CRD + CORDIC_STEPS;
    localparam int S_P2    = S_P1 + 1;
    localparam int S_Q1    = S_P2 + 1;
    localparam int S_M1    = S_Q1 + SQRT_STEPS;
    localparam int S_M2    = S_M1 + 1;
    localparam int S_M3    = S_M2 + 1;
    localparam int S_M4    = S_M3 + 1;
    localparam int S_Q2    = S_M4 + 1;
    localparam int S_D0    = S_Q2 + SQRT_STEPS;
    localparam int S_DV    = S_D0 + 1;
    localparam int S_DE    = S_DV + DIV_STEPS;
    localparam int S_R     = S_DE + 1;
    localparam int S_Q3    = S_R + 1;
    localparam int S_F1    = S_Q3 + SQRT_STEPS;
    localparam int S_F2    = S_F1 + 1;
    localparam int NSTAGE  = S_F2 + 1;
    localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;

    item_t              pipe_reg [NSTAGE];
    logic [NSTAGE-1:0]  valid_reg;
    logic [NSTAGE-1:0]  valid_next;
    logic               advance;

    // the whole pipeline moves unless a finished result is being held
    assign advance    = !(valid_reg[NSTAGE-1] && sun_stall);
    assign item_stall = !advance;
    assign valid_next = {valid_reg[NSTAGE-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= valid_next;
    end

    genvar k;
    generate
        for (k = 0; k < NSTAGE; k++)
        begin : g_stage
            item_t stage_next;

            if (k == 0)
            begin : g_in
                // request capture
                always_comb
                begin
                    stage_next      = pipe_reg[0];
                    stage_next.lat  = latitude;
                    stage_next.day  = day_of_year;
                    stage_next.mins = minute_of_day;
                end
            end
            else if (k == S_ANG)
            begin : g_ang
                // angles in q30 radians
                always_comb
                begin
                    stage_next       = pipe_reg[k-1];
                    stage_next.ang_l = ang_scale(16'(pipe_reg[k-1].lat), LAT_RAD_Q40);
                    stage_next.ang_d = ang_scale($signed({7'b0, pipe_reg[k-1].day})
                                                 - DAY_ZERO, DAY_RAD_Q40);
                    stage_next.ang_h = ang_scale($signed({5'b0, pipe_reg[k-1].mins})
                                                 - MIN_NOON, MIN_RAD_Q40);
                end
            end
            else if (k == S_RED)
            begin : g_red
                always_comb
                begin
                    stage_next       = pipe_reg[k-1];
                    stage_next.rot_l = rot_start(pipe_reg[k-1].ang_l);
                    stage_next.rot_d = rot_start(pipe_reg[k-1].ang_d);
                    stage_next.rot_h = rot_start(pipe_reg[k-1].ang_h);
                end
            end
            else if (k >= S_CRD && k < S_P1)
            begin : g_crd
                // one rotation step in each of the three lanes
                always_comb
                begin
                    stage_next       = pipe_reg[k-1];
                    stage_next.rot_l = rot_step(pipe_reg[k-1].rot_l, k - S_CRD);
                    stage_next.rot_d = rot_step(pipe_reg[k-1].rot_d, k - S_CRD);
                    stage_next.rot_h = rot_step(pipe_reg[k-1].rot_h, k - S_CRD);
                end
            end
            else if (k == S_P1)
            begin : g_p1
                // sine of declination from the day angle, plus the latitude and hour-angle terms
                always_comb
                begin
                    stage_next        = pipe_reg[k-1];
                    stage_next.sl     = rot_sin(pipe_reg[k-1].rot_l);
                    stage_next.cl     = rot_cos(pipe_reg[k-1].rot_l);
                    stage_next.ch     = rot_cos(pipe_reg[k-1].rot_h);
                    stage_next.sh_pos = (rot_sin(pipe_reg[k-1].rot_h) > 32'sd0);
                    stage_next.sd     = mulq(TILT_Q30, rot_cos(pipe_reg[k-1].rot_d));
                end
            end
            else if (k == S_P2)
            begin : g_p2
                always_comb
                begin
                    stage_next         = pipe_reg[k-1];
                    stage_next.sd_sl   = mulq(pipe_reg[k-1].sd, pipe_reg[k-1].sl);
                    stage_next.sd_cl   = mulq(pipe_reg[k-1].sd, pipe_reg[k-1].cl);
                    stage_next.sq.rem  = co_arg(pipe_reg[k-1].sd);
                    stage_next.sq.root = '0;
                end
            end
            else if (k >= S_Q1 && k < S_M1)
            begin : g_sq1
                // cos of declination
                always_comb
                begin
                    stage_next    = pipe_reg[k-1];
                    stage_next.sq = sq_step(pipe_reg[k-1].sq, k - S_Q1);
                end
            end
            else if (k == S_M1)
            begin : g_m1
                always_comb
                begin
                    stage_next    = pipe_reg[k-1];
                    stage_next.t1 = mulq($signed(pipe_reg[k-1].sq.root[31:0]),
                                         pipe_reg[k-1].ch);
                    stage_next.t2 = mulq($signed(pipe_reg[k-1].sq.root[31:0]),
                                         pipe_reg[k-1].sl);
                end
            end
            else if (k == S_M2)
            begin : g_m2
                always_comb
                begin
                    stage_next    = pipe_reg[k-1];
                    stage_next.u1 = mulq(pipe_reg[k-1].t1, pipe_reg[k-1].cl);
                    stage_next.u2 = mulq(pipe_reg[k-1].t2, pipe_reg[k-1].ch);
                end
            end
            else if (k == S_M3)
            begin : g_m3
                // sine of elevation and the azimuth numerator
                always_comb
                begin
                    stage_next     = pipe_reg[k-1];
                    stage_next.sel = clamp_unit(34'(pipe_reg[k-1].sd_sl)
                                                + 34'(pipe_reg[k-1].u1));
                    stage_next.num = 33'(pipe_reg[k-1].sd_cl) - 33'(pipe_reg[k-1].u2);
                end
            end
            else if (k == S_M4)
            begin : g_m4
                always_comb
                begin
                    stage_next         = pipe_reg[k-1];
                    stage_next.sq.rem  = co_arg(pipe_reg[k-1].sel);
                    stage_next.sq.root = '0;
                end
            end
            else if (k >= S_Q2 && k < S_D0)
            begin : g_sq2
                // cos of elevation
                always_comb
                begin
                    stage_next    = pipe_reg[k-1];
                    stage_next.sq = sq_step(pipe_reg[k-1].sq, k - S_Q2);
                end
            end
            else if (k == S_D0)
            begin : g_d0
                // a numerator at or above cos(el) saturates the ratio, zero cos(el) too
                logic [32:0] mag;
                q30_t        cel_v;
                always_comb
                begin
                    cel_v          = $signed(pipe_reg[k-1].sq.root[31:0]);
                    mag            = pipe_reg[k-1].num[32] ? $unsigned(-pipe_reg[k-1].num)
                                                           : $unsigned(pipe_reg[k-1].num);
                    stage_next     = pipe_reg[k-1];
                    stage_next.cel = cel_v;
                    stage_next.neg = pipe_reg[k-1].num[32];
                    stage_next.sat = (mag >= {1'b0, $unsigned(cel_v)});
                    stage_next.dv.rem = stage_next.sat ? 32'd0 : mag[31:0];
                    stage_next.dv.quo = '0;
                end
            end
            else if (k >= S_DV && k < S_DE)
            begin : g_dv
                always_comb
                begin
                    stage_next    = pipe_reg[k-1];
                    stage_next.dv = div_step(pipe_reg[k-1].dv, pipe_reg[k-1].cel);
                end
            end
            else if (k == S_DE)
            begin : g_de
                // quotient truncated toward zero
                q30_t quo_v;
                always_comb
                begin
                    quo_v      = $signed({2'b00, pipe_reg[k-1].dv.quo});
                    stage_next = pipe_reg[k-1];
                    if (pipe_reg[k-1].sat)
                        stage_next.ratio = pipe_reg[k-1].neg ? -ONE_Q30 : ONE_Q30;
                    else
                        stage_next.ratio = pipe_reg[k-1].neg ? -quo_v : quo_v;
                end
            end
            else if (k == S_R)
            begin : g_r
                always_comb
                begin
                    stage_next         = pipe_reg[k-1];
                    stage_next.zprod   = mulq(pipe_reg[k-1].ratio, pipe_reg[k-1].cel);
                    stage_next.sq.rem  = co_arg(pipe_reg[k-1].ratio);
                    stage_next.sq.root = '0;
                end
            end
            else if (k >= S_Q3 && k < S_F1)
            begin : g_sq3
                // magnitude of sin of azimuth
                always_comb
                begin
                    stage_next    = pipe_reg[k-1];
                    stage_next.sq = sq_step(pipe_reg[k-1].sq, k - S_Q3);
                end
            end
            else if (k == S_F1)
            begin : g_f1
                // azimuth mirrored in the afternoon
                q30_t saz;
                always_comb
                begin
                    saz = $signed(pipe_reg[k-1].sq.root[31:0]);
                    if (pipe_reg[k-1].sh_pos)
                        saz = -saz;
                    stage_next       = pipe_reg[k-1];
                    stage_next.xprod = mulq(saz, pipe_reg[k-1].cel);
                end
            end
            else
            begin : g_out
                // output register
                always_comb
                begin
                    stage_next       = pipe_reg[k-1];
                    stage_next.sun_x = to_out(-34'(pipe_reg[k-1].xprod), OUT_SHIFT);
                    stage_next.sun_y = to_out(34'(pipe_reg[k-1].sel), OUT_SHIFT);
                    stage_next.sun_z = to_out(34'(pipe_reg[k-1].zprod), OUT_SHIFT);
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                    pipe_reg[k] <= stage_next;
            end
        end
    endgenerate

    assign sun_valid = valid_reg[NSTAGE-1];
    assign sun_x     = pipe_reg[NSTAGE-1].sun_x;
    assign sun_y     = pipe_reg[NSTAGE-1].sun_y;
    assign sun_z     = pipe_reg[NSTAGE-1].sun_z;

endmodule

FILE: tb/sv/tb_solar_direction_from_time_unit.sv
// ----------------------------------------------------------------------------
// tb_solar_direction_from_time_unit : self-checking bench for the sun vector
// drives latitude / day / minute requests with random gaps and output stalls,
// predicts each x/y/z vector with an independent fixed-point model and
// compares every returned vector in order
// ----------------------------------------------------------------------------
module tb_solar_direction_from_time_unit
    import sdft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // fixed-point constants of the solar model, q30 unless marked
    localparam longint Q_ONE     = 64'sd1073741824;
    localparam longint Q_PI      = 64'sd3373259426;
    localparam longint Q_HALF_PI = 64'sd1686629713;
    localparam longint Q_TWO_PI  = 64'sd6746518852;
    localparam longint Q_K0      = 64'sd652032874;
    localparam longint Q_TILT    = 64'sd427295559;
    localparam longint LAT_K40   = 64'sd191900981;
    localparam longint DAY_K40   = 64'sd18914336361;
    localparam longint MIN_K40   = 64'sd4797524517;
    localparam int     N_STEPS   = CORDIC_STEPS_DEF;
    localparam int     OUT_SHIFT = 30 - OUT_FRAC_BITS_DEF;
    localparam int     PIPE_LAT  = 137 + CORDIC_STEPS_DEF;
    localparam int     IDLE_LIMIT = 4000;
    localparam int     N_RANDOM  = 1830;

    localparam longint ARCTAN [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } sun_vec_t;

    typedef struct {
        int lat;
        int day;
        int mins;
    } site_req_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [14:0] latitude;
    logic [8:0]         day_of_year;
    logic [10:0]        minute_of_day;
    logic               sun_valid;
    logic               sun_stall;
    logic signed [15:0] sun_x;
    logic signed [15:0] sun_y;
    logic signed [15:0] sun_z;

    sun_vec_t sun_dir_q [$];
    int       err_count = 0;
    int       idle_cycles = 0;
    bit       quiet;

    solar_direction_from_time_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .latitude      (latitude),
        .day_of_year   (day_of_year),
        .minute_of_day (minute_of_day),
        .sun_valid     (sun_valid),
        .sun_stall     (sun_stall),
        .sun_x         (sun_x),
        .sun_y         (sun_y),
        .sun_z         (sun_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint prod_q30(longint a, longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic longint unit_clip(longint v);
        if (v > Q_ONE)
            return Q_ONE;
        if (v < -Q_ONE)
            return -Q_ONE;
        return v;
    endfunction

    // floor square root, one digit pair per pass
    function automatic longint floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return longint'(root);
    endfunction

    // cosine from sine (or the reverse), never negative
    function automatic longint co_side(longint s);
        longint c;
        c = unit_clip(s);
        return floor_root(longint'(64'd1 << 60) - c * c);
    endfunction

    // cordic sine and cosine of a q30 angle in radians
    function automatic void rotate_angle(input longint a, output longint sv,
                                         output longint cv);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        x = Q_K0;
        y = 0;
        z = a;
        flip = 0;
        while (z > Q_PI)
            z = z - Q_TWO_PI;
        while (z <= -Q_PI)
            z = z + Q_TWO_PI;
        if (z > Q_HALF_PI)
        begin
            z = Q_PI - z;
            flip = 1;
        end
        else if (z < -Q_HALF_PI)
        begin
            z = -Q_PI - z;
            flip = 1;
        end
        for (int i = 0; i < N_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        sv = unit_clip(y);
        cv = unit_clip(flip ? -x : x);
    endfunction

    function automatic logic signed [15:0] q30_to_out(longint v);
        longint q;
        q = rnd_shift(v, OUT_SHIFT);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    function automatic sun_vec_t sun_direction(logic signed [14:0] lat_f,
                                               logic [8:0] day_f,
                                               logic [10:0] min_f);
        longint sl, cl, sb, cb, sh, ch, sd, cd, sel, cel, num, ratio, saz;
        sun_vec_t r;
        rotate_angle(rnd_shift(longint'(lat_f) * LAT_K40, 10), sl, cl);
        rotate_angle(rnd_shift((longint'(day_f) - 173) * DAY_K40, 10), sb, cb);
        rotate_angle(rnd_shift((longint'(min_f) - 720) * MIN_K40, 10), sh, ch);
        sd  = prod_q30(Q_TILT, cb);
        cd  = co_side(sd);
        sel = unit_clip(prod_q30(sd, sl) + prod_q30(prod_q30(cd, ch), cl));
        cel = co_side(sel);
        num = prod_q30(sd, cl) - prod_q30(prod_q30(cd, sl), ch);
        // sun at zenith or nadir: azimuth ratio saturates on the sign
        if (cel == 0)
            ratio = (num < 0) ? -Q_ONE : Q_ONE;
        else
            ratio = unit_clip((num * Q_ONE) / cel);
        saz = co_side(ratio);
        // afternoon mirrors the azimuth
        if (sh > 0)
            saz = -saz;
        r.x = q30_to_out(-prod_q30(saz, cel));
        r.y = q30_to_out(sel);
        r.z = q30_to_out(prod_q30(ratio, cel));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side: prediction on every accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sun_dir_q.insert(sun_dir_q.size(),
                             sun_direction(latitude, day_of_year, minute_of_day));
    end

    // ------------------------------------------------------------------
    // result side: compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sun_vec_t want;
        if (rst_n && sun_valid && !sun_stall)
        begin
            if (sun_dir_q.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                         $realtime, sun_x, sun_y, sun_z);
                err_count++;
            end
            else
            begin
                want = sun_dir_q.pop_front();
                if (sun_x !== want.x)
                begin
                    $display("%0t: sun_x expected %0d actual %0d", $realtime, want.x, sun_x);
                    err_count++;
                end
                if (sun_y !== want.y)
                begin
                    $display("%0t: sun_y expected %0d actual %0d", $realtime, want.y, sun_y);
                    err_count++;
                end
                if (sun_z !== want.z)
                begin
                    $display("%0t: sun_z expected %0d actual %0d", $realtime, want.z, sun_z);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output back-pressure: bursts of stall and go, mostly short
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int burst;
        int r;
        if (!rst_n || quiet)
            sun_stall <= 1'b0;
        else if (burst > 0)
            burst--;
        else
        begin
            r = $urandom_range(0, 99);
            burst = (r < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            sun_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no handshake on either side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (sun_valid && !sun_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request driver: random gap, then hold until taken
    // ------------------------------------------------------------------
    task automatic send_site(int lat, int day, int mins);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        latitude      <= 15'(lat);
        day_of_year   <= 9'(day);
        minute_of_day <= 11'(mins);
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // wait for every predicted vector to come back
    task automatic drain_results();
        item_valid <= 1'b0;
        while (sun_dir_q.size() != 0)
            @(posedge clk);
    endtask

    // directed sites: field extremes, solstices, noon and midnight, poles,
    // sun near the zenith (latitude close to the declination at noon), and
    // bit patterns outside the nominal ranges that wrap onto the circle
    site_req_t dir_sites [22] = '{
        '{0, 173, 720},     '{0, 1, 0},         '{9000, 173, 720},
        '{-9000, 173, 720}, '{9000, 356, 0},    '{-9000, 356, 1439},
        '{2345, 173, 720},  '{2346, 173, 720},  '{-2345, 356, 720},
        '{0, 80, 720},      '{0, 80, 360},      '{0, 80, 1080},
        '{4500, 366, 1439}, '{-4500, 1, 1},     '{5000, 200, 719},
        '{5000, 200, 721},  '{-16384, 0, 2047}, '{16383, 511, 0},
        '{0, 0, 0},         '{-1, 511, 2047},   '{3000, 173, 720},
        '{-3000, 45, 600}
    };

    initial
    begin
        int lat;
        int day;
        int mins;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        latitude      = '0;
        day_of_year   = 9'd1;
        minute_of_day = '0;
        quiet         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_sites[k])
            send_site(dir_sites[k].lat, dir_sites[k].day, dir_sites[k].mins);

        // sender holds off until the pipe is empty, then restarts
        drain_results();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // alternate stretches with and without idling
            if (n % 300 == 0)
                quiet <= ~quiet;
            if (n == 900)
                drain_results();
            if ($urandom_range(0, 4) == 0)
            begin
                lat  = $urandom_range(0, 32767);
                day  = $urandom_range(0, 511);
                mins = $urandom_range(0, 2047);
            end
            else
            begin
                lat  = int'($urandom_range(0, 18000)) - 9000;
                day  = $urandom_range(1, 366);
                mins = $urandom_range(0, 1439);
            end
            send_site(lat, day, mins);
        end

        quiet <= 1'b0;
        drain_results();
        repeat (PIPE_LAT + 50) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
